>>> rtl/core/led_span_antialias_render_macros.svh
// ----------------------------------------------------------------------------
// LED span renderer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LED_SPAN_ANTIALIAS_RENDER_MACROS_SVH
`define LED_SPAN_ANTIALIAS_RENDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lsar_pkg.sv
// ----------------------------------------------------------------------------
// LED span renderer package
// Field types, fixed-point constants, register codes and sequencer states.
// ----------------------------------------------------------------------------
package lsar_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int ONE_INT    = 1 << FRAC_BITS;
    localparam int MAX_PIXELS = 4096;
    localparam int MAX_SPAN   = 64;

    localparam int POS_W = 21;
    localparam int WID_W = 14;
    localparam int COL_W = 8;
    localparam int IDX_W = 12;
    localparam int CFG_W = 13;
    localparam int WGT_W = FRAC_BITS + 1;
    localparam int SCL_W = 2 * WGT_W - FRAC_BITS;
    localparam int PIX_W = 16;
    localparam int EXT_W = 24;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [WID_W-1:0]        wid_t;
    typedef logic [COL_W-1:0]        col_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CFG_W-1:0]        cfg_t;
    typedef logic [WGT_W-1:0]        wgt_t;
    typedef logic signed [PIX_W-1:0] pix_t;
    typedef logic [2:0][WGT_W-1:0]   lanes_t;
    typedef logic [2:0][SCL_W-1:0]   scaled_t;

    localparam wgt_t ONE_W       = WGT_W'(ONE_INT);
    localparam cfg_t STRIP_RESET = CFG_W'(4096);

    typedef enum logic [0:0] {
        REG_ANTIALIAS,
        REG_STRIP_LEN
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_PROD,
        S_CLIP,
        S_RUN
    } state_t;

    typedef struct packed {
        pix_t first;
        pix_t last;
        wgt_t lw;
        wgt_t rw;
    } span_t;

endpackage

>>> rtl/core/lsar_if.sv
// ----------------------------------------------------------------------------
// LED span renderer channels
// Object input channel and pixel contribution output channel.
// ----------------------------------------------------------------------------
interface lsar_obj_if;
    import lsar_pkg::*;

    logic valid;
    logic ready;
    pos_t center_pos;
    wid_t span_width;
    col_t red_in;
    col_t green_in;
    col_t blue_in;

    modport source (output valid, center_pos, span_width, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, center_pos, span_width, red_in, green_in, blue_in,
                  output ready);
endinterface

interface lsar_pix_if;
    import lsar_pkg::*;

    logic valid;
    logic ready;
    idx_t pixel_index;
    col_t red_out;
    col_t green_out;
    col_t blue_out;
    logic last_of_span;

    modport source (output valid, pixel_index, red_out, green_out, blue_out, last_of_span,
                    input ready);
    modport sink (input valid, pixel_index, red_out, green_out, blue_out, last_of_span,
                  output ready);
endinterface

>>> rtl/core/lsar_span_setup.sv
// ----------------------------------------------------------------------------
// LED span edge setup
// Finds the first and last pixel of an object and the coverage of both edges.
// ----------------------------------------------------------------------------
module lsar_span_setup (
    input  lsar_pkg::pos_t  center_pos,
    input  lsar_pkg::wid_t  span_width,
    input  logic            antialias_on,
    output lsar_pkg::span_t span
);
    import lsar_pkg::*;

    localparam int SH = FRAC_BITS + 1;
    localparam logic signed [EXT_W-1:0] ONE_E   = EXT_W'(ONE_INT);
    localparam logic signed [EXT_W-1:0] UNIT_M1 = EXT_W'((1 << SH) - 1);

    logic signed [EXT_W-1:0] p2;
    logic signed [EXT_W-1:0] w_e;
    logic signed [EXT_W-1:0] l2;
    logic signed [EXT_W-1:0] r2;
    logic signed [EXT_W-1:0] first_e;
    logic signed [EXT_W-1:0] last_e;
    logic [SH-1:0]           frac_l;
    logic [SH-1:0]           frac_r;
    logic [SH:0]             lw_full;
    logic [SH:0]             rw_full;
    logic [WID_W:0]          w_half;
    logic [PIX_W-1:0]        cnt_u;
    logic                    rnd_mode;

    always_comb
    begin
        p2 = {{(EXT_W-POS_W-1){center_pos[POS_W-1]}}, center_pos, 1'b0};
        w_e = {{(EXT_W-WID_W){1'b0}}, span_width};
        l2 = p2 - w_e + ONE_E;
        r2 = p2 + w_e - ONE_E;
        first_e = l2 >>> SH;
        // Ceiling of the right edge: bias by one unit less one, then floor.
        last_e = (r2 + UNIT_M1) >>> SH;

        frac_l = l2[SH-1:0];
        frac_r = ~r2[SH-1:0] + 1'b1;
        lw_full = (SH+1)'(1 << SH) - {1'b0, frac_l};
        rw_full = (SH+1)'(1 << SH) - {1'b0, frac_r};

        w_half = {1'b0, span_width} + (WID_W+1)'(ONE_INT / 2);
        cnt_u = (span_width == '0) ? PIX_W'(1) : PIX_W'(w_half >> FRAC_BITS);
        rnd_mode = (span_width == '0) || !antialias_on;

        span.first = first_e[PIX_W-1:0];
        if (rnd_mode)
        begin
            span.last = first_e[PIX_W-1:0] + signed'(cnt_u) - pix_t'(1);
            span.lw = ONE_W;
            span.rw = ONE_W;
        end
        else
        begin
            span.last = last_e[PIX_W-1:0];
            span.lw = lw_full[SH:1];
            span.rw = rw_full[SH:1];
        end
    end
endmodule

>>> rtl/core/lsar_scale.sv
// ----------------------------------------------------------------------------
// LED span weight scaler
// Shared unit: three lanes of operand times weight, scaled down by one.
// ----------------------------------------------------------------------------
module lsar_scale (
    input  lsar_pkg::wgt_t    weight,
    input  lsar_pkg::lanes_t  operand,
    output lsar_pkg::scaled_t scaled
);
    import lsar_pkg::*;

    logic [2:0][2*WGT_W-1:0] prod;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = operand[i] * weight;
            scaled[i] = prod[i][2*WGT_W-1:FRAC_BITS];
        end
    end
endmodule

>>> rtl/core/led_span_antialias_render.sv
// Flow: an accepted object passes through the edge, product and clip states, then
// the walk, which loads each contribution into the output register. An object emits
// at most 64 contributions, or none; no new object is taken until its walk is over.
// The span walk steps one pixel per cycle while the output is not stalled.
// Reset clears the sequencer and the output valid, sets antialias_on to 1 and
// strip_length to 4096.
// ----------------------------------------------------------------------------
// LED span antialias renderer
// Turns one light object into the run of weighted pixel contributions that
// are added into a one-dimensional LED strip.
// ----------------------------------------------------------------------------
`include "led_span_antialias_render_macros.svh"

module led_span_antialias_render (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  lsar_pkg::reg_idx_t cfg_index,
    input  lsar_pkg::cfg_t     cfg_data,
    lsar_obj_if.sink           obj,
    lsar_pix_if.source         pix
);
    import lsar_pkg::*;

    // Effective strip length can never exceed what the length register holds.
    localparam int   LIM_CAP   = (MAX_PIXELS > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1
                                                                  : MAX_PIXELS;
    localparam pix_t SPAN_LAST = PIX_W'(MAX_SPAN - 1);

    // Configuration registers.
    logic aa_reg;
    cfg_t strip_len_reg;

    // Sequencer.
    state_t state_reg;
    state_t state_next;

    // Captured object.
    pos_t pos_reg;
    wid_t wid_reg;
    col_t red_reg;
    col_t green_reg;
    col_t blue_reg;

    // Span under construction and the walk over it.
    pix_t first_reg;
    pix_t last_reg;
    wgt_t lw_reg;
    wgt_t rw_reg;
    pix_t cur_reg;
    pix_t hi_reg;

    // Output register.
    logic pix_valid_reg;
    idx_t pix_index_reg;
    col_t pix_red_reg;
    col_t pix_green_reg;
    col_t pix_blue_reg;
    logic pix_last_reg;

    span_t   span;
    wgt_t    scl_weight;
    lanes_t  scl_operand;
    scaled_t scaled;
    cfg_t    limit;
    pix_t    lim_last;
    pix_t    span_diff;
    pix_t    lo_raw;
    pix_t    hi_raw;
    pix_t    lo_clip;
    pix_t    hi_clip;
    wgt_t    pix_weight;
    logic    emit;
    logic    run_done;

    // ------------------------------------------------------------------
    // Configuration port. Writes must come only while the block is idle; not enforced.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aa_reg <= 1'b1;
            strip_len_reg <= STRIP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANTIALIAS: aa_reg <= cfg_data[0];
                REG_STRIP_LEN: strip_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Object capture. The object is held for the whole walk.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (obj.valid && obj.ready)
        begin
            pos_reg <= obj.center_pos;
            wid_reg <= obj.span_width;
            red_reg <= obj.red_in;
            green_reg <= obj.green_in;
            blue_reg <= obj.blue_in;
        end
    end

    // Edge setup works from the captured object; its result is registered
    // in the edge state.
    lsar_span_setup u_setup (
        .center_pos   (pos_reg),
        .span_width   (wid_reg),
        .antialias_on (aa_reg),
        .span         (span)
    );

    // The shared scaler forms the product of both edge weights for a
    // one-pixel span, and the weighted colour of every emitted pixel.
    lsar_scale u_scale (
        .weight  (scl_weight),
        .operand (scl_operand),
        .scaled  (scaled)
    );

    // ------------------------------------------------------------------
    // Span trimming and clipping.
    // ------------------------------------------------------------------
    always_comb
    begin
        limit = (strip_len_reg > CFG_W'(LIM_CAP)) ? CFG_W'(LIM_CAP) : strip_len_reg;
        lim_last = signed'({{(PIX_W-CFG_W){1'b0}}, limit}) - pix_t'(1);
        span_diff = last_reg - first_reg;

        // An edge of zero weight drops out, which keeps the survivors contiguous.
        lo_raw = first_reg + signed'({{(PIX_W-1){1'b0}}, (lw_reg == '0)});
        hi_raw = last_reg
               - signed'({{(PIX_W-1){1'b0}}, ((first_reg != last_reg) && (rw_reg == '0))});
        lo_clip = lo_raw[PIX_W-1] ? '0 : lo_raw;
        hi_clip = (hi_raw > lim_last) ? lim_last : hi_raw;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (obj.valid)
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE: state_next = S_PROD;
            S_PROD: state_next = S_CLIP;
            S_CLIP:
            begin
                if (lo_clip > hi_clip)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (run_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. The scaler serves the edge product in the
    // product state and the colour channels during the walk.
    // ------------------------------------------------------------------
    always_comb
    begin
        obj.ready = (state_reg == S_IDLE);
        emit = (state_reg == S_RUN) && (!pix_valid_reg || pix.ready);
        run_done = emit && (cur_reg == hi_reg);

        if (cur_reg == first_reg)
        begin
            pix_weight = lw_reg;
        end
        else if (cur_reg == last_reg)
        begin
            pix_weight = rw_reg;
        end
        else
        begin
            pix_weight = ONE_W;
        end

        case (state_reg)
            S_PROD:
            begin
                scl_weight = rw_reg;
                scl_operand[0] = lw_reg;
                scl_operand[1] = '0;
                scl_operand[2] = '0;
            end
            default:
            begin
                scl_weight = pix_weight;
                scl_operand[0] = {1'b0, red_reg};
                scl_operand[1] = {1'b0, green_reg};
                scl_operand[2] = {1'b0, blue_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Span datapath. Edge state loads the raw span; product state caps
    // an overlong span and folds both weights of a one-pixel span into
    // one; clip state sets the walk bounds; run state steps the pixel.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_EDGE:
            begin
                first_reg <= span.first;
                last_reg <= span.last;
                lw_reg <= span.lw;
                rw_reg <= span.rw;
            end
            S_PROD:
            begin
                if (span_diff > SPAN_LAST)
                begin
                    last_reg <= first_reg + SPAN_LAST;
                end
                if (first_reg == last_reg)
                begin
                    lw_reg <= scaled[0][WGT_W-1:0];
                end
            end
            S_CLIP:
            begin
                cur_reg <= lo_clip;
                hi_reg <= hi_clip;
            end
            S_RUN:
            begin
                if (emit)
                begin
                    cur_reg <= cur_reg + pix_t'(1);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register. The walk advances only when this slot is free or
    // being taken, so an item is never lost or repeated.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_index_reg <= cur_reg[IDX_W-1:0];
            pix_red_reg <= scaled[0][COL_W-1:0];
            pix_green_reg <= scaled[1][COL_W-1:0];
            pix_blue_reg <= scaled[2][COL_W-1:0];
            pix_last_reg <= (cur_reg == hi_reg);
        end
    end

    assign pix.valid = pix_valid_reg;
    assign pix.pixel_index = pix_index_reg;
    assign pix.red_out = pix_red_reg;
    assign pix.green_out = pix_green_reg;
    assign pix.blue_out = pix_blue_reg;
    assign pix.last_of_span = pix_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LSAR_ASSERT_NEXT(a_last_ends_walk, run_done, state_reg == S_IDLE, "walk did not end on last item")
    `LSAR_ASSERT_NOW(a_walk_in_strip, state_reg == S_RUN, (!cur_reg[PIX_W-1]) && (cur_reg <= hi_reg) && (cur_reg <= lim_last), "walk left the strip")
    `LSAR_ASSERT_NOW(a_weights_bounded, state_reg == S_CLIP, (lw_reg <= ONE_W) && (rw_reg <= ONE_W), "edge weight above one")
    `LSAR_ASSERT_NEXT(a_span_capped, state_reg == S_PROD, span_diff <= SPAN_LAST || last_reg == first_reg + SPAN_LAST, "span not capped")
endmodule
